/* rtl/core/rti_pkg.sv */
package rti_pkg;

  // Limb width of the split multiplier; one limb product per DSP-sized multiply
  localparam int LIMB = 32;

  // Registers inside one rti_mul, input to product
  localparam int MUL_LAT = 5;

  // Single-precision epsilon exponent for the near-zero determinant test
  localparam int EPS_LOG2 = 23;

  // Configuration register index
  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_ORIGIN_Z = 2'd2
  } reg_idx_t;

endpackage

/* rtl/core/rti_mul.sv */
// Pipelined signed multiplier built from LIMB x LIMB partial products.
// Five register stages: magnitude, partial products, row sums, total, sign.
module rti_mul #(
  parameter int WA = 33,
  parameter int WB = 66
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int L   = rti_pkg::LIMB;
  localparam int NA  = (WA + L - 1) / L;
  localparam int NB  = (WB + L - 1) / L;
  localparam int RWD = (NB + 1) * L;
  localparam int TW  = (NA + NB) * L;

  logic [WA-1:0]           abs_a;
  logic [WB-1:0]           abs_b;
  logic [NA*L-1:0]         ma_r;
  logic [NB*L-1:0]         mb_r;
  logic                    s1_r, s2_r, s3_r, s4_r;
  logic [2*L-1:0]          pp_r [NA][NB];
  logic [RWD-1:0]          row_nxt [NA];
  logic [RWD-1:0]          row_r [NA];
  logic [TW-1:0]           tot_nxt;
  logic [TW-1:0]           tot_r;
  logic signed [WA+WB-1:0] p_r;

  // magnitudes; the most negative value maps onto its own unsigned magnitude
  assign abs_a = a[WA-1] ? WA'(-a) : WA'(a);
  assign abs_b = b[WB-1] ? WB'(-b) : WB'(b);

  // one row of partial products per limb of a
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RWD'(pp_r[i][j]) << (j * L));
      end
    end
  end

  // rows into the full magnitude
  always_comb begin
    tot_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      tot_nxt = tot_nxt + (TW'(row_r[i]) << (i * L));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= (NA*L)'(abs_a);
      mb_r <= (NB*L)'(abs_b);
      s1_r <= a[WA-1] ^ b[WB-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ma_r[i*L +: L] * mb_r[j*L +: L];
        end
      end
      s2_r <= s1_r;
      row_r <= row_nxt;
      s3_r <= s2_r;
      tot_r <= tot_nxt;
      s4_r <= s3_r;
      p_r <= s4_r ? -$signed(tot_r[WA+WB-1:0]) : $signed(tot_r[WA+WB-1:0]);
    end
  end

  assign p = p_r;

endmodule

/* rtl/core/ray_triangle_intersect_top.sv */
// Moller-Trumbore ray/triangle test in signed fixed point, no back-face culling.
// One word in per clock while in_tready is high, one result out per word, in
// order. The pipeline holds two five-stage split multipliers (cross, then dot
// products), four stages of sum, sign fold, hit test and overflow test, then a
// restoring divider that retires one quotient bit per stage for t, u and v at
// once. A stalled output stops the pipeline only when its last stage holds a
// result, so bubbles are squeezed out. The ray origin lives in three registers
// on the APB port (x at 0, y at 4, z at 8 when COORD_BITS is at most 32); write
// them only while no word is in flight. On a miss out_tuser is 0 and out_tdata
// is all zero.
module ray_triangle_intersect_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int IN_W   = ((12 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W  = ((COORD_BITS + 2 * (FRAC_BITS + 1) + 7) / 8) * 8,
  localparam int CFG_DW = (COORD_BITS > 32) ? 64 : 32,
  localparam int CFG_SL = (COORD_BITS > 32) ? 3 : 2,
  localparam int CFG_AW = CFG_SL + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // dir_x, dir_y, dir_z, vertex_a_x..z, vertex_b_x..z, vertex_c_x..z
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // hit_distance, bary_u, bary_v
  output logic [OUT_W-1:0]  out_tdata,
  // hit
  output logic              out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int UW  = F + 1;
  localparam int EW  = C + 1;
  localparam int PW  = 2 * C + 2;
  localparam int QW  = 2 * C + 3;
  localparam int NW  = 3 * C + 6;
  localparam int ML  = rti_pkg::MUL_LAT;
  localparam int DS  = (C - 1 > F + 1) ? C - 1 : F + 1;
  localparam int RW  = NW + DS + 1;
  localparam int VL  = 2 * ML + 6 + DS;
  localparam logic signed [C-1:0]  ORG_Z_RST = C'(1) << F;
  localparam logic signed [NW-1:0] DET_LIM   = NW'(1) << (3 * F - rti_pkg::EPS_LOG2);
  localparam logic signed [C-1:0]  T_MAX     = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0]  T_MIN     = {1'b1, {(C-1){1'b0}}};

  // ---------------------------------------------------------------- config
  logic                    cfg_wr;
  logic [1:0]              cfg_idx;
  logic signed [C-1:0]     org_r [3];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:CFG_SL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= ORG_Z_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rti_pkg::REG_ORIGIN_X: org_r[0] <= cfg_pwdata[C-1:0];
        rti_pkg::REG_ORIGIN_Y: org_r[1] <= cfg_pwdata[C-1:0];
        rti_pkg::REG_ORIGIN_Z: org_r[2] <= cfg_pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rti_pkg::REG_ORIGIN_X: cfg_prdata = CFG_DW'(org_r[0]);
      rti_pkg::REG_ORIGIN_Y: cfg_prdata = CFG_DW'(org_r[1]);
      rti_pkg::REG_ORIGIN_Z: cfg_prdata = CFG_DW'(org_r[2]);
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  logic          en;
  logic [VL-1:0] v_r;
  logic          out_tvalid_r;

  // advance unless the last stage holds a result the output cannot take
  assign en        = !v_r[VL-1] || !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (en) v_r <= {v_r[VL-2:0], in_tvalid};
      if (en && v_r[VL-1]) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stage 0: edges
  logic signed [C-1:0]  in_d [3];
  logic signed [C-1:0]  in_a [3];
  logic signed [C-1:0]  in_b [3];
  logic signed [C-1:0]  in_c [3];
  logic signed [C-1:0]  d0_r [3];
  logic signed [EW-1:0] e1_0_r [3];
  logic signed [EW-1:0] e2_0_r [3];
  logic signed [EW-1:0] t0_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_d[k] = in_tdata[k*C +: C];
      in_a[k] = in_tdata[(3+k)*C +: C];
      in_b[k] = in_tdata[(6+k)*C +: C];
      in_c[k] = in_tdata[(9+k)*C +: C];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d0_r[k]   <= in_d[k];
        e1_0_r[k] <= EW'(in_b[k]) - EW'(in_a[k]);
        e2_0_r[k] <= EW'(in_c[k]) - EW'(in_a[k]);
        t0_r[k]   <= EW'(org_r[k]) - EW'(in_a[k]);
      end
    end
  end

  // vectors delayed to line up with P and Q
  logic signed [C-1:0]  dl_d_r  [ML+1][3];
  logic signed [EW-1:0] dl_e1_r [ML+1][3];
  logic signed [EW-1:0] dl_e2_r [ML+1][3];
  logic signed [EW-1:0] dl_t_r  [ML+1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dl_d_r[0][k]  <= d0_r[k];
        dl_e1_r[0][k] <= e1_0_r[k];
        dl_e2_r[0][k] <= e2_0_r[k];
        dl_t_r[0][k]  <= t0_r[k];
        for (int s = 1; s <= ML; s++) begin
          dl_d_r[s][k]  <= dl_d_r[s-1][k];
          dl_e1_r[s][k] <= dl_e1_r[s-1][k];
          dl_e2_r[s][k] <= dl_e2_r[s-1][k];
          dl_t_r[s][k]  <= dl_t_r[s-1][k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- cross products
  logic signed [C+EW-1:0] pa [3];
  logic signed [C+EW-1:0] pb [3];
  logic signed [2*EW-1:0] qa [3];
  logic signed [2*EW-1:0] qb [3];
  logic signed [PW-1:0]   p_r [3];
  logic signed [QW-1:0]   q_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_cross
    rti_mul #(.WA(C), .WB(EW)) u_pa (
      .clk(clk), .en(en), .a(d0_r[(k+1)%3]), .b(e2_0_r[(k+2)%3]), .p(pa[k]));
    rti_mul #(.WA(C), .WB(EW)) u_pb (
      .clk(clk), .en(en), .a(d0_r[(k+2)%3]), .b(e2_0_r[(k+1)%3]), .p(pb[k]));
    rti_mul #(.WA(EW), .WB(EW)) u_qa (
      .clk(clk), .en(en), .a(t0_r[(k+1)%3]), .b(e1_0_r[(k+2)%3]), .p(qa[k]));
    rti_mul #(.WA(EW), .WB(EW)) u_qb (
      .clk(clk), .en(en), .a(t0_r[(k+2)%3]), .b(e1_0_r[(k+1)%3]), .p(qb[k]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= PW'(pa[k]) - PW'(pb[k]);
        q_r[k] <= QW'(qa[k]) - QW'(qb[k]);
      end
    end
  end

  // ---------------------------------------------------------------- dot products
  logic signed [EW+PW-1:0] m_det [3];
  logic signed [EW+PW-1:0] m_nu  [3];
  logic signed [C+QW-1:0]  m_nv  [3];
  logic signed [EW+QW-1:0] m_nt  [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    rti_mul #(.WA(EW), .WB(PW)) u_det (
      .clk(clk), .en(en), .a(dl_e1_r[ML][k]), .b(p_r[k]), .p(m_det[k]));
    rti_mul #(.WA(EW), .WB(PW)) u_nu (
      .clk(clk), .en(en), .a(dl_t_r[ML][k]), .b(p_r[k]), .p(m_nu[k]));
    rti_mul #(.WA(C), .WB(QW)) u_nv (
      .clk(clk), .en(en), .a(dl_d_r[ML][k]), .b(q_r[k]), .p(m_nv[k]));
    rti_mul #(.WA(EW), .WB(QW)) u_nt (
      .clk(clk), .en(en), .a(dl_e2_r[ML][k]), .b(q_r[k]), .p(m_nt[k]));
  end

  logic signed [NW-1:0] det_r, nu_r, nv_r, nt_r;
  logic signed [NW-1:0] det1_r, nu1_r, nv1_r, nt1_r;
  logic                 miss2_r, tneg2_r;
  logic [NW-1:0]        tabs2_r, det2_r, nu2_r, nv2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // sum of products
      det_r <= NW'(m_det[0]) + NW'(m_det[1]) + NW'(m_det[2]);
      nu_r  <= NW'(m_nu[0]) + NW'(m_nu[1]) + NW'(m_nu[2]);
      nv_r  <= NW'(m_nv[0]) + NW'(m_nv[1]) + NW'(m_nv[2]);
      nt_r  <= NW'(m_nt[0]) + NW'(m_nt[1]) + NW'(m_nt[2]);
      // fold the determinant sign into everything
      det1_r <= det_r[NW-1] ? -det_r : det_r;
      nu1_r  <= det_r[NW-1] ? -nu_r  : nu_r;
      nv1_r  <= det_r[NW-1] ? -nv_r  : nv_r;
      nt1_r  <= det_r[NW-1] ? -nt_r  : nt_r;
      // hit test, boundaries inclusive
      miss2_r <= (det1_r < DET_LIM) || nu1_r[NW-1] || (det1_r < nu1_r) ||
                 nv1_r[NW-1] || (det1_r < nu1_r + nv1_r);
      tneg2_r <= nt1_r[NW-1];
      tabs2_r <= nt1_r[NW-1] ? NW'(-nt1_r) : NW'(nt1_r);
      det2_r  <= NW'(det1_r);
      nu2_r   <= NW'(nu1_r);
      nv2_r   <= NW'(nv1_r);
    end
  end

  // ---------------------------------------------------------------- divider
  // lane 0 = t, lane 1 = u, lane 2 = v; entry 0 is the setup stage
  logic [RW-1:0] rem_r  [DS+1][3];
  logic [DS-1:0] quo_r  [DS+1][3];
  logic [NW-1:0] ddet_r [DS+1];
  logic          dmiss_r [DS+1];
  logic          dtneg_r [DS+1];
  logic          dovf_r  [DS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0][0] <= RW'(tabs2_r) << F;
      rem_r[0][1] <= RW'(nu2_r) << F;
      rem_r[0][2] <= RW'(nv2_r) << F;
      for (int m = 0; m < 3; m++) quo_r[0][m] <= '0;
      ddet_r[0]  <= det2_r;
      dmiss_r[0] <= miss2_r;
      dtneg_r[0] <= tneg2_r;
      // t beyond the signed range saturates
      dovf_r[0]  <= (RW'(tabs2_r) << F) >= (RW'(det2_r) << (C - 1));
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [RW-1:0] dsh;
    logic [2:0]    ge;

    assign dsh = RW'(ddet_r[j]) << (DS - 1 - j);

    always_comb begin
      for (int m = 0; m < 3; m++) ge[m] = rem_r[j][m] >= dsh;
    end

    // one quotient bit per stage, restoring
    always_ff @(posedge clk) begin
      if (en) begin
        for (int m = 0; m < 3; m++) begin
          rem_r[j+1][m] <= ge[m] ? rem_r[j][m] - dsh : rem_r[j][m];
          quo_r[j+1][m] <= quo_r[j][m] | (DS'(ge[m]) << (DS - 1 - j));
        end
        ddet_r[j+1]  <= ddet_r[j];
        dmiss_r[j+1] <= dmiss_r[j];
        dtneg_r[j+1] <= dtneg_r[j];
        dovf_r[j+1]  <= dovf_r[j];
      end
    end
  end

  // ---------------------------------------------------------------- output
  logic [C-1:0]        t_mag;
  logic signed [C-1:0] t_val;
  logic [UW-1:0]       u_val, v_val;
  logic [OUT_W-1:0]    out_tdata_r;
  logic                out_tuser_r;

  assign t_mag = C'(quo_r[DS][0]);
  assign u_val = quo_r[DS][1][UW-1:0];
  assign v_val = quo_r[DS][2][UW-1:0];

  always_comb begin
    if (dovf_r[DS]) t_val = dtneg_r[DS] ? T_MIN : T_MAX;
    else            t_val = dtneg_r[DS] ? -$signed(t_mag) : $signed(t_mag);
  end

  always_ff @(posedge clk) begin
    if (en && v_r[VL-1]) begin
      out_tuser_r <= !dmiss_r[DS];
      out_tdata_r <= dmiss_r[DS] ? '0 : OUT_W'({v_val, u_val, t_val});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------- checks
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss word carries nonzero data");

  a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ((UW+1)'(out_tdata[C +: UW]) + (UW+1)'(out_tdata[C+UW +: UW]))
        <= ((UW+1)'(1) << F))
    else $error("u + v above one on a hit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline moved while stalled");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[VL-1] |=> out_tvalid)
    else $error("finished word not presented");

endmodule

/* test/ray_triangle_intersect_top_tb.sv */
`timescale 1ns / 100ps

module ray_triangle_intersect_top_tb;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 384;
  localparam int OUT_W      = 72;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int DRAIN_CYC  = 80;
  // byte address past the last origin register
  localparam logic [3:0] UNUSED_ADDR = 4'd12;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_dist;
    logic [16:0] u;
    logic [16:0] v;
  } hit_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // dir_x, dir_y, dir_z, vertex_a_x..z, vertex_b_x..z, vertex_c_x..z
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // hit_distance, bary_u, bary_v
  logic [OUT_W-1:0]  out_tdata;
  // hit
  logic              out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [3:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  logic signed [31:0] ray_origin [3];
  hit_result_t        expected_hits [$];
  int                 mismatches = 0;
  int                 stall_left = 0;

  ray_triangle_intersect_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Exact Moller-Trumbore on wide signed vectors; division truncates toward zero
  function automatic hit_result_t intersect_ray(logic [IN_W-1:0] w);
    wide_t dv[3], av[3], bv[3], cv[3], e1[3], e2[3], tv[3], p[3], q[3];
    wide_t det, nu, nv, nt, tq, lim, hi, lo;
    hit_result_t r;
    for (int i = 0; i < 3; i++) begin
      dv[i] = $signed(w[32*i +: 32]);
      av[i] = $signed(w[32*(3+i) +: 32]);
      bv[i] = $signed(w[32*(6+i) +: 32]);
      cv[i] = $signed(w[32*(9+i) +: 32]);
      e1[i] = bv[i] - av[i];
      e2[i] = cv[i] - av[i];
      tv[i] = wide_t'(ray_origin[i]) - av[i];
    end
    p[0] = dv[1] * e2[2] - dv[2] * e2[1];
    p[1] = dv[2] * e2[0] - dv[0] * e2[2];
    p[2] = dv[0] * e2[1] - dv[1] * e2[0];
    q[0] = tv[1] * e1[2] - tv[2] * e1[1];
    q[1] = tv[2] * e1[0] - tv[0] * e1[2];
    q[2] = tv[0] * e1[1] - tv[1] * e1[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    nu  = tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2];
    nv  = dv[0] * q[0] + dv[1] * q[1] + dv[2] * q[2];
    nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    // fold the sign of det into the numerators
    if (det < 0) begin
      det = -det;
      nu = -nu;
      nv = -nv;
      nt = -nt;
    end
    r = '0;
    lim = 1;
    lim = lim <<< (3 * FRAC_BITS - rti_pkg::EPS_LOG2);
    if (det < lim) return r;
    if (nu < 0 || nu > det) return r;
    if (nv < 0 || nu + nv > det) return r;
    hi = 2147483647;
    lo = -hi - 1;
    tq = (nt <<< FRAC_BITS) / det;
    if (tq > hi) tq = hi;
    if (tq < lo) tq = lo;
    r.hit = 1'b1;
    r.hit_dist = tq[31:0];
    tq = (nu <<< FRAC_BITS) / det;
    r.u = tq[16:0];
    tq = (nv <<< FRAC_BITS) / det;
    r.v = tq[16:0];
    return r;
  endfunction

  function automatic logic [IN_W-1:0] ray_word(int dx, int dy, int dz, int ax, int ay, int az,
                                               int bx, int by, int bz, int cx, int cy, int cz);
    return {cz, cy, cx, bz, by, bx, az, ay, ax, dz, dy, dx};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Sends one word; called just after a rising edge, returns likewise
  task automatic send_ray(logic [IN_W-1:0] w);
    int r, gap;
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    expected_hits.push_back(intersect_ray(w));
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Setup phase, then access phase, then bus idle before the next transfer
  task automatic write_reg(logic [3:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == 4 * rti_pkg::REG_ORIGIN_X) ray_origin[0] = data;
    else if (addr == 4 * rti_pkg::REG_ORIGIN_Y) ray_origin[1] = data;
    else if (addr == 4 * rti_pkg::REG_ORIGIN_Z) ray_origin[2] = data;
    @(posedge clk);
  endtask

  task automatic set_origin(int ox, int oy, int oz);
    wait_drained();
    write_reg(4'(4 * rti_pkg::REG_ORIGIN_X), ox);
    write_reg(4'(4 * rti_pkg::REG_ORIGIN_Y), oy);
    write_reg(4'(4 * rti_pkg::REG_ORIGIN_Z), oz);
  endtask

  // Unit triangle in z=0 seen from the reset origin: vertices, edges, faces
  task automatic test_unit_triangle();
    send_ray(ray_word(0, 0, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_ray(ray_word(ONE, 0, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_ray(ray_word(0, ONE, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_ray(ray_word(ONE/2, ONE/2, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_ray(ray_word(ONE/2, 0, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_ray(ray_word(ONE/4, ONE/3, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_ray(ray_word(ONE, ONE, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_ray(ray_word(-ONE/8, ONE/4, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    // hit behind the origin
    send_ray(ray_word(0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    // ray parallel to the plane
    send_ray(ray_word(ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    // back face: winding reversed
    send_ray(ray_word(ONE/4, ONE/4, -ONE, 0, 0, 0, 0, ONE, 0, ONE, 0, 0));
    // near-zero determinant on a tiny triangle, then exactly at the threshold
    send_ray(ray_word(0, 0, -ONE, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_ray(ray_word(0, 0, -ONE, 0, 0, 0, 32, 0, 0, 0, 16, 0));
    // far plane with a tiny step: distance saturates
    send_ray(ray_word(0, 0, -1, -1000*ONE, -1000*ONE, -30000*ONE, 1000*ONE, -1000*ONE,
                      -30000*ONE, 0, 1000*ONE, -30000*ONE));
    send_ray(ray_word(0, 0, 1, -1000*ONE, -1000*ONE, 30000*ONE, 1000*ONE, -1000*ONE,
                      30000*ONE, 0, 1000*ONE, 30000*ONE));
  endtask

  // Field extremes under extreme origins, plus a write to no register
  task automatic test_extremes();
    set_origin(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_ray('0);
    send_ray({12{32'h7fff_ffff}});
    send_ray({12{32'h8000_0000}});
    send_ray({6{32'h8000_0000, 32'h7fff_ffff}});
    send_ray({6{32'h7fff_ffff, 32'h8000_0000}});
    send_ray({12{32'hffff_ffff}});
    set_origin(32'h7fff_ffff, 32'h8000_0000, 0);
    wait_drained();
    write_reg(UNUSED_ADDR, 32'hdead_beef);
    send_ray({{3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {6{32'h0}}});
    send_ray(ray_word(1, -1, 32'h7fff_ffff, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_ray({12{32'h5555_aaaa}});
    send_ray({12{32'haaaa_5555}});
  endtask

  // Mostly rays aimed at a random point of a random triangle, some pure noise
  task automatic test_random_rays(int count);
    int sh, k1, k2;
    longint ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
    logic [IN_W-1:0] w;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3) begin
        for (int i = 0; i < 12; i++) w[32*i +: 32] = $urandom();
      end else begin
        sh = $urandom_range(4, 28);
        ax = $signed($urandom()) >>> (31 - sh); ay = $signed($urandom()) >>> (31 - sh);
        az = $signed($urandom()) >>> (31 - sh); bx = $signed($urandom()) >>> (31 - sh);
        by = $signed($urandom()) >>> (31 - sh); bz = $signed($urandom()) >>> (31 - sh);
        cx = $signed($urandom()) >>> (31 - sh); cy = $signed($urandom()) >>> (31 - sh);
        cz = $signed($urandom()) >>> (31 - sh);
        k1 = $urandom_range(0, 1024);
        k2 = $urandom_range(0, 1024 - k1);
        // sometimes right on an edge or a vertex
        if ($urandom_range(0, 7) == 0) k1 = 0;
        if ($urandom_range(0, 7) == 0) k2 = 1024 - k1;
        px = ax + ((bx - ax) * k1 + (cx - ax) * k2) / 1024;
        py = ay + ((by - ay) * k1 + (cy - ay) * k2) / 1024;
        pz = az + ((bz - az) * k1 + (cz - az) * k2) / 1024;
        px -= ray_origin[0]; py -= ray_origin[1]; pz -= ray_origin[2];
        if ($urandom_range(0, 5) == 0) begin
          px = -px; py = -py; pz = -pz;
        end
        w = ray_word(int'(px), int'(py), int'(pz), int'(ax), int'(ay), int'(az),
                     int'(bx), int'(by), int'(bz), int'(cx), int'(cy), int'(cz));
      end
      send_ray(w);
    end
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    hit_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[31:0], 32'h0);
      end else begin
        want = expected_hits.pop_front();
        if (out_tuser !== want.hit) report_mismatch("hit", out_tuser, want.hit);
        if (out_tdata[31:0] !== want.hit_dist) begin
          report_mismatch("distance", out_tdata[31:0], want.hit_dist);
        end
        if (out_tdata[48:32] !== want.u) report_mismatch("bary_u", out_tdata[48:32], want.u);
        if (out_tdata[65:49] !== want.v) report_mismatch("bary_v", out_tdata[65:49], want.v);
      end
    end
  end

  // Receiver stalls: runs of ready, short and occasional long stalls
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        stall_left <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else if (r < 10) begin
        stall_left <= $urandom_range(10, 40);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    ray_origin[0] = 0;
    ray_origin[1] = 0;
    ray_origin[2] = ONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unit_triangle();
    test_extremes();
    set_origin(0, 0, ONE);
    test_random_rays(100);
    set_origin($urandom(), $urandom(), $urandom());
    test_random_rays(100);
    set_origin(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_random_rays(50);
    set_origin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    test_random_rays(50);
    set_origin($signed($urandom()) >>> 8, $signed($urandom()) >>> 8, $signed($urandom()) >>> 8);
    test_random_rays(100);
    wait_drained();
    if (mismatches == 0) begin
      $display("ray_triangle_intersect_top_tb: PASS");
    end else begin
      $display("ray_triangle_intersect_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ray_triangle_intersect_top_tb: FAIL");
    $finish;
  end

endmodule
